>>> rtl/checksummed_reply_deframer_macros.svh
// assertion macros used by the deframer core rtl
`ifndef CHECKSUMMED_REPLY_DEFRAMER_MACROS_SVH
`define CHECKSUMMED_REPLY_DEFRAMER_MACROS_SVH

// same-cycle implication, disabled during reset
`define CRD_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled during reset
`define CRD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/crd_pkg.sv
// ----------------------------------------------------------------------------
// crd_pkg
// types and constants shared by the reply deframer modules
// ----------------------------------------------------------------------------
package crd_pkg;

	typedef enum logic [1:0] {
		PH_IDLE = 2'd0,
		PH_HUNT = 2'd1,
		PH_LEN  = 2'd2,
		PH_BODY = 2'd3
	} phase_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_TIMEOUT  = 2'd1,
		ST_CHKSUM   = 2'd2,
		ST_UNSUPP   = 2'd3
	} status_t;

	typedef enum logic {
		REG_TIMEOUT_LIMIT = 1'b0,
		REG_START_CODE    = 1'b1
	} reg_index_t;

	localparam logic [15:0] TIMEOUT_RESET    = 16'd50000;
	localparam logic [7:0]  START_CODE_RESET = 8'h81;
	localparam logic [7:0]  TYPE_UNSUPPORTED = 8'hFF;
	localparam logic [7:0]  MIN_LENGTH       = 8'd3;
	localparam logic [7:0]  POS_TYPE         = 8'd2;
	localparam logic [7:0]  POS_PARAM        = 8'd3;
	localparam logic [7:0]  LEN_WITH_PARAM   = 8'd4;

	typedef struct packed {
		logic       valid;
		logic [7:0] rx_byte;
		logic       begin_req;
	} item_t;

	typedef struct packed {
		status_t    status;
		logic [7:0] frame_length;
		logic [7:0] frame_type;
		logic [7:0] first_param;
	} result_t;

endpackage

>>> rtl/crd_in_stage.sv
// ----------------------------------------------------------------------------
// crd_in_stage
// input register holding one received byte until the core takes it
// ----------------------------------------------------------------------------
module crd_in_stage (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_stall,
	input  logic [7:0]      rx_byte,
	input  logic            begin_req,
	input  logic            advance,
	output crd_pkg::item_t  item_s1
);
	import crd_pkg::*;

	logic       valid_s1;
	logic [7:0] rx_byte_s1;
	logic       begin_s1;
	logic       accept;

	assign in_stall = valid_s1 && !advance;
	assign accept   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rx_byte_s1 <= rx_byte;
			begin_s1   <= begin_req;
		end
	end

	assign item_s1 = '{valid: valid_s1, rx_byte: rx_byte_s1, begin_req: begin_s1};

endmodule

>>> rtl/crd_core.sv
// ----------------------------------------------------------------------------
// crd_core
// frame state update per byte and registered result output
// ----------------------------------------------------------------------------
module crd_core (
	input  logic             clk,
	input  logic             arst_n,
	input  crd_pkg::item_t   item_s1,
	output logic             advance,
	input  logic [15:0]      timeout_limit,
	input  logic [7:0]       start_code,
	output logic             out_valid,
	input  logic             out_stall,
	output crd_pkg::result_t result
);
	import crd_pkg::*;
	`include "checksummed_reply_deframer_macros.svh"

	phase_t     phase_q, phase_nxt;
	logic [15:0] hunt_q, hunt_nxt;
	logic [7:0]  sum_q, sum_nxt;
	logic [7:0]  len_q, len_nxt;
	logic [7:0]  pos_q, pos_nxt;
	logic [7:0]  type_q, type_nxt;
	logic [7:0]  param_q, param_nxt;

	logic        out_valid_q;
	result_t     result_q;

	logic [15:0] hunt_inc;
	logic        limit_zero;
	logic        hunt_hit;
	logic        start_hit;
	logic        short_len;
	logic        body_more;
	logic [7:0]  b;
	logic [7:0]  type_eff;
	logic [7:0]  param_eff;

	logic        res_valid;
	result_t     res;

	assign advance   = item_s1.valid && (!out_valid_q || !out_stall);
	assign b         = item_s1.rx_byte;
	assign hunt_inc  = hunt_q + 16'd1;
	assign limit_zero = (timeout_limit == 16'd0);
	assign hunt_hit  = (hunt_inc >= timeout_limit);
	assign start_hit = (b == start_code);
	assign short_len = (b < MIN_LENGTH);
	assign body_more = ({1'b0, pos_q} + 9'd1) < {1'b0, len_q};
	assign type_eff  = (pos_q == POS_TYPE) ? b : type_q;
	assign param_eff = (pos_q == POS_PARAM) ? b : param_q;

	// next phase
	always_comb begin
		phase_nxt = phase_q;
		if (item_s1.begin_req) begin
			phase_nxt = limit_zero ? PH_IDLE : PH_HUNT;
		end else begin
			unique case (phase_q)
				PH_IDLE: phase_nxt = PH_IDLE;
				PH_HUNT: begin
					if (hunt_hit) begin
						phase_nxt = PH_IDLE;
					end else if (start_hit) begin
						phase_nxt = PH_LEN;
					end
				end
				PH_LEN:  phase_nxt = short_len ? PH_IDLE : PH_BODY;
				PH_BODY: phase_nxt = body_more ? PH_BODY : PH_IDLE;
				default: phase_nxt = PH_IDLE;
			endcase
		end
	end

	// datapath and result
	always_comb begin
		hunt_nxt  = hunt_q;
		sum_nxt   = sum_q;
		len_nxt   = len_q;
		pos_nxt   = pos_q;
		type_nxt  = type_q;
		param_nxt = param_q;
		res_valid = 1'b0;
		res       = '{status: ST_OK, frame_length: 8'd0, frame_type: 8'd0, first_param: 8'd0};
		if (item_s1.begin_req) begin
			hunt_nxt  = 16'd0;
			sum_nxt   = 8'd0;
			len_nxt   = 8'd0;
			pos_nxt   = 8'd0;
			type_nxt  = 8'd0;
			param_nxt = 8'd0;
			if (limit_zero) begin
				res_valid  = 1'b1;
				res.status = ST_TIMEOUT;
			end
		end else begin
			unique case (phase_q)
				PH_IDLE: begin
				end
				PH_HUNT: begin
					hunt_nxt = hunt_inc;
					if (hunt_hit) begin
						res_valid  = 1'b1;
						res.status = ST_TIMEOUT;
					end else if (start_hit) begin
						sum_nxt = start_code;
					end
				end
				PH_LEN: begin
					len_nxt = b;
					sum_nxt = sum_q + b;
					if (short_len) begin
						res_valid        = 1'b1;
						res.status       = ST_CHKSUM;
						res.frame_length = b;
					end else begin
						pos_nxt = POS_TYPE;
					end
				end
				PH_BODY: begin
					type_nxt  = type_eff;
					param_nxt = param_eff;
					if (body_more) begin
						sum_nxt = sum_q + b;
						pos_nxt = pos_q + 8'd1;
					end else begin
						res_valid        = 1'b1;
						res.frame_length = len_q;
						res.frame_type   = type_eff;
						res.first_param  = (len_q >= LEN_WITH_PARAM) ? param_eff : 8'd0;
						if (sum_q != b) begin
							res.status = ST_CHKSUM;
						end else if (type_eff == TYPE_UNSUPPORTED) begin
							res.status = ST_UNSUPP;
						end else begin
							res.status = ST_OK;
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			hunt_q  <= 16'd0;
			sum_q   <= 8'd0;
			len_q   <= 8'd0;
			pos_q   <= 8'd0;
			type_q  <= 8'd0;
			param_q <= 8'd0;
		end else if (advance) begin
			phase_q <= phase_nxt;
			hunt_q  <= hunt_nxt;
			sum_q   <= sum_nxt;
			len_q   <= len_nxt;
			pos_q   <= pos_nxt;
			type_q  <= type_nxt;
			param_q <= param_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= res_valid;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res_valid) begin
			result_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign result    = result_q;

	`CRD_ASSERT_NEXT(a_idle_after_result, clk, arst_n, advance && res_valid,
		phase_q == PH_IDLE, "phase not idle after a result")
	`CRD_ASSERT_NOW(a_body_position, clk, arst_n, phase_q == PH_BODY,
		pos_q >= POS_TYPE && pos_q < len_q, "body position out of range")
	`CRD_ASSERT_NOW(a_timeout_fields, clk, arst_n,
		out_valid_q && result_q.status == ST_TIMEOUT,
		result_q.frame_length == 8'd0 && result_q.frame_type == 8'd0 &&
		result_q.first_param == 8'd0, "timeout result carries frame data")
	`CRD_ASSERT_NOW(a_ok_type, clk, arst_n, out_valid_q && result_q.status == ST_OK,
		result_q.frame_type != TYPE_UNSUPPORTED, "ok status on unsupported type")

endmodule

>>> rtl/checksummed_reply_deframer.sv
// ----------------------------------------------------------------------------
// checksummed_reply_deframer
// recovers one checksummed reply frame per receive request from link bytes
// ----------------------------------------------------------------------------
// channel   direction  handshake           payload
// in        sink       in_valid/in_stall   rx_byte, begin_req
// out       source     out_valid/out_stall status, frame_length, frame_type,
//                                           first_param
// cfg       sink       cfg_wr_en           cfg_index, cfg_data
//
// one byte per cycle sustained while out_stall is low; a byte passes the input
// register, the state update and the result register
// reset clears the frame state and loads timeout 50000 and start code 0x81
// a stalled result holds the input register; the next byte waits in it
// ----------------------------------------------------------------------------
module checksummed_reply_deframer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  rx_byte,
	input  logic        begin_req,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  status,
	output logic [7:0]  frame_length,
	output logic [7:0]  frame_type,
	output logic [7:0]  first_param,
	input  logic        cfg_wr_en,
	input  logic        cfg_index,
	input  logic [15:0] cfg_data
);
	import crd_pkg::*;

	logic [15:0] timeout_limit_q;
	logic [7:0]  start_code_q;
	item_t       item_s1;
	logic        advance;
	result_t     result;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_limit_q <= TIMEOUT_RESET;
			start_code_q    <= START_CODE_RESET;
		end else if (cfg_wr_en) begin
			unique case (reg_index_t'(cfg_index))
				REG_TIMEOUT_LIMIT: timeout_limit_q <= cfg_data;
				REG_START_CODE:    start_code_q    <= cfg_data[7:0];
				default: begin
				end
			endcase
		end
	end

	crd_in_stage u_in_stage (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.rx_byte   (rx_byte),
		.begin_req (begin_req),
		.advance   (advance),
		.item_s1   (item_s1)
	);

	crd_core u_core (
		.clk           (clk),
		.arst_n        (arst_n),
		.item_s1       (item_s1),
		.advance       (advance),
		.timeout_limit (timeout_limit_q),
		.start_code    (start_code_q),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.result        (result)
	);

	assign status       = result.status;
	assign frame_length = result.frame_length;
	assign frame_type   = result.frame_type;
	assign first_param  = result.first_param;

endmodule
